>>> rtl/etl_pkg.sv
`default_nettype none

package etl_pkg;

	typedef enum logic [3:0] {
		KIND_END       = 4'd0,
		KIND_INT       = 4'd1,
		KIND_FLOAT     = 4'd2,
		KIND_SYM       = 4'd3,
		KIND_COMMA     = 4'd4,
		KIND_LPAREN    = 4'd5,
		KIND_RPAREN    = 4'd6,
		KIND_SEMICOLON = 4'd7,
		KIND_OPERATOR  = 4'd8,
		KIND_ERROR     = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		OP_ASSIGN = 3'd0,
		OP_PLUS   = 3'd1,
		OP_MINUS  = 3'd2,
		OP_MUL    = 3'd3,
		OP_DIV    = 3'd4,
		OP_MOD    = 3'd5,
		OP_POW    = 3'd6
	} op_t;

	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_INT  = 5'b00010,
		MODE_DOT  = 5'b00100,
		MODE_SYM  = 5'b01000,
		MODE_ERR  = 5'b10000
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] cursor;
		logic [15:0] pend_start;
		logic        frac;
	} lex_state_t;

	typedef struct packed {
		kind_t       kind;
		op_t         op;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	localparam int unsigned MaxTokens = 3;

	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_SEMICOLON  = 8'h3B;
	localparam logic [7:0] CH_EQUAL      = 8'h3D;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;

endpackage

`default_nettype wire

>>> rtl/etl_char_if.sv
`default_nettype none

interface etl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       char_valid;
	logic       end_of_text;

	modport source(output valid, output char_code, output char_valid, output end_of_text,
		input ready);
	modport sink(input valid, input char_code, input char_valid, input end_of_text,
		output ready);
endinterface

`default_nettype wire

>>> rtl/etl_token_if.sv
`default_nettype none

interface etl_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [2:0]  operator_code;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source(output valid, output token_kind, output operator_code, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input operator_code, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/expression_token_lexer.sv
// path: a character is registered in the input stage, its tokens then in the token buffer
// throughput: one character per cycle while each yields at most one token and the sink
// is ready; a character with more tokens holds the input stage until its last one pops
// reset: arst_n clears lexer state (offset 0, idle), the input stage and the token buffer
`default_nettype none

module expression_token_lexer
	import etl_pkg::*;
#(
	parameter longint unsigned MAX_TEXT_LENGTH = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	etl_char_if.sink           chars,
	etl_token_if.source        tokens
);

	localparam logic [15:0] POS_CAP =
		(MAX_TEXT_LENGTH < 64'd65535) ? 16'(MAX_TEXT_LENGTH) : 16'hFFFF;

	logic        valid_s1;
	logic [7:0]  char_code_s1;
	logic        char_valid_s1;
	logic        end_of_text_s1;

	lex_state_t   state_q;
	lex_state_t   state_next;
	token_t [2:0] lex_toks;
	logic [1:0]   lex_count;
	logic [15:0]  cursor_inc;

	token_t [2:0] buf_q;
	logic [1:0]   cnt_q;

	logic pop;
	logic load;

	assign pop    = tokens.valid && tokens.ready;
	assign load   = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
	assign chars.ready = !valid_s1 || load;

	assign cursor_inc = (state_q.cursor < POS_CAP) ? (state_q.cursor + 16'd1) : state_q.cursor;

	etl_lex u_lex (
		.st          (state_q),
		.char_code   (char_code_s1),
		.char_valid  (char_valid_s1),
		.end_of_text (end_of_text_s1),
		.cursor_inc  (cursor_inc),
		.st_next     (state_next),
		.toks        (lex_toks),
		.count       (lex_count)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_code_s1   <= chars.char_code;
			char_valid_s1  <= chars.char_valid;
			end_of_text_s1 <= chars.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lex_state_t'{mode: MODE_IDLE, cursor: 16'd0, pend_start: 16'd0,
				frac: 1'b0};
		end else if (load) begin
			state_q <= state_next;
		end
	end

	// token buffer, drained from the front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= lex_count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= lex_toks;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	assign tokens.valid         = (cnt_q != 2'd0);
	assign tokens.token_kind    = buf_q[0].kind;
	assign tokens.operator_code = buf_q[0].op;
	assign tokens.token_start   = buf_q[0].start;
	assign tokens.token_length  = buf_q[0].length;
	assign tokens.last_of_run   = buf_q[0].last;

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (cnt_q == 2'd1) |-> tokens.last_of_run)
		else $error("last token of a run lacks last_of_run");

	a_not_last_early: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (cnt_q > 2'd1) |-> !tokens.last_of_run)
		else $error("last_of_run set before the run is drained");

	a_end_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (tokens.token_kind == KIND_END) |-> (tokens.token_length == 16'd0))
		else $error("end token with nonzero length");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		load && end_of_text_s1 |=> (state_q.cursor == 16'd0) && (state_q.mode == MODE_IDLE))
		else $error("lexer state not cleared after end of text");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load && char_valid_s1 && !end_of_text_s1 |-> (lex_count != 2'd3))
		else $error("character without end of text produced three tokens");

endmodule

`default_nettype wire

>>> rtl/etl_lex.sv
`default_nettype none

module etl_lex
	import etl_pkg::*;
(
	input  lex_state_t         st,
	input  logic [7:0]         char_code,
	input  logic               char_valid,
	input  logic               end_of_text,
	input  logic [15:0]        cursor_inc,
	output lex_state_t         st_next,
	output token_t [2:0]       toks,
	output logic [1:0]         count
);

	logic is_d, is_a, is_u, is_s;

	assign is_d = (char_code >= "0") && (char_code <= "9");
	assign is_a = ((char_code >= "a") && (char_code <= "z")) ||
		((char_code >= "A") && (char_code <= "Z"));
	assign is_u = (char_code == CH_UNDERSCORE);
	assign is_s = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));

	always_comb begin : lex_blk
		mode_t        mode;
		logic [15:0]  start;
		logic [15:0]  cur2;
		logic [15:0]  plen;
		logic [15:0]  plen2;
		logic         frac;
		logic [1:0]   n;
		token_t [2:0] r;
		logic         close_en;
		logic         begin_en;
		kind_t        ckind;
		kind_t        pkind;
		op_t          pop;

		mode     = st.mode;
		start    = st.pend_start;
		frac     = st.frac;
		n        = 2'd0;
		r        = '0;
		close_en = 1'b0;
		begin_en = 1'b0;
		ckind    = KIND_INT;
		pkind    = KIND_OPERATOR;
		pop      = OP_ASSIGN;
		plen     = (st.cursor >= st.pend_start) ? (st.cursor - st.pend_start) : 16'd0;

		if (char_valid) begin
			unique case (st.mode)
				MODE_INT: begin
					if (!is_d) begin
						if (char_code == CH_DOT) begin
							mode = MODE_DOT;
							frac = 1'b0;
						end else begin
							close_en = 1'b1;
							ckind    = KIND_INT;
						end
					end
				end
				MODE_DOT: begin
					if (is_d) begin
						frac = 1'b1;
					end else begin
						close_en = 1'b1;
						ckind    = st.frac ? KIND_FLOAT : KIND_INT;
					end
				end
				MODE_SYM: begin
					if (!(is_a || is_d || is_u)) begin
						r[n] = token_t'{kind: KIND_SYM, op: OP_ASSIGN, start: st.pend_start,
							length: plen, last: 1'b0};
						n        = n + 2'd1;
						mode     = MODE_IDLE;
						begin_en = 1'b1;
					end
				end
				MODE_ERR: begin
				end
				MODE_IDLE: begin
					begin_en = 1'b1;
				end
				default: begin
					mode     = MODE_IDLE;
					begin_en = 1'b1;
				end
			endcase

			// letter right after a number is an error covering the number
			if (close_en) begin
				if (is_a) begin
					r[n] = token_t'{kind: KIND_ERROR, op: OP_ASSIGN, start: st.pend_start,
						length: plen, last: 1'b0};
					n    = n + 2'd1;
					mode = MODE_ERR;
				end else begin
					r[n] = token_t'{kind: ckind, op: OP_ASSIGN, start: st.pend_start,
						length: plen, last: 1'b0};
					n        = n + 2'd1;
					mode     = MODE_IDLE;
					begin_en = 1'b1;
				end
			end

			if (begin_en) begin
				if (is_s) begin
					mode = MODE_IDLE;
				end else if (is_d) begin
					mode  = MODE_INT;
					start = st.cursor;
				end else if (is_a || is_u) begin
					mode  = MODE_SYM;
					start = st.cursor;
				end else begin
					case (char_code)
						CH_COMMA:     pkind = KIND_COMMA;
						CH_LPAREN:    pkind = KIND_LPAREN;
						CH_RPAREN:    pkind = KIND_RPAREN;
						CH_SEMICOLON: pkind = KIND_SEMICOLON;
						CH_EQUAL:     pop = OP_ASSIGN;
						CH_PLUS:      pop = OP_PLUS;
						CH_MINUS:     pop = OP_MINUS;
						CH_STAR:      pop = OP_MUL;
						CH_SLASH:     pop = OP_DIV;
						CH_PERCENT:   pop = OP_MOD;
						CH_CARET:     pop = OP_POW;
						default:      pkind = KIND_ERROR;
					endcase
					r[n] = token_t'{kind: pkind, op: pop, start: st.cursor, length: 16'd1,
						last: 1'b0};
					n    = n + 2'd1;
					mode = (pkind == KIND_ERROR) ? MODE_ERR : MODE_IDLE;
				end
			end
		end

		cur2  = char_valid ? cursor_inc : st.cursor;
		plen2 = (cur2 >= start) ? (cur2 - start) : 16'd0;

		if (end_of_text) begin
			if (mode == MODE_INT || mode == MODE_DOT || mode == MODE_SYM) begin
				r[n] = token_t'{kind: (mode == MODE_SYM) ? KIND_SYM :
					((mode == MODE_DOT && frac) ? KIND_FLOAT : KIND_INT),
					op: OP_ASSIGN, start: start, length: plen2, last: 1'b0};
				n    = n + 2'd1;
			end
			r[n] = token_t'{kind: KIND_END, op: OP_ASSIGN, start: cur2, length: 16'd0,
				last: 1'b0};
			n       = n + 2'd1;
			st_next = lex_state_t'{mode: MODE_IDLE, cursor: 16'd0, pend_start: 16'd0,
				frac: 1'b0};
		end else begin
			st_next = lex_state_t'{mode: mode, cursor: cur2, pend_start: start, frac: frac};
		end

		if (n != 2'd0) begin
			r[n - 2'd1].last = 1'b1;
		end

		toks  = r;
		count = n;
	end

endmodule

`default_nettype wire

>>> bench/tb_expression_token_lexer.sv
`default_nettype none

module tb_expression_token_lexer;
	import etl_pkg::*;

	localparam logic [15:0] CursorCap = 16'hFFFF;
	localparam int unsigned QuietLimit = 1000;
	localparam int unsigned DrainCycles = 10;
	localparam int unsigned RandomItems = 360;
	localparam int unsigned LongSymbolChars = 12;

	typedef struct packed {
		logic [7:0] code;
		logic       cv;
		logic       eot;
		logic [3:0] gap;
	} char_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	etl_char_if  char_bus();
	etl_token_if token_bus();

	expression_token_lexer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.tokens (token_bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	char_item_t  char_queue[$];
	token_t      expected_tokens[$];
	char_item_t  next_item;
	char_item_t  on_bus;
	token_t      want;
	logic        staged;
	int unsigned hold;
	int unsigned sink_wait;
	logic        src_calm = 1'b0;
	logic        sink_calm = 1'b0;
	int unsigned items_made = 0;
	int unsigned items_total = 0;
	int unsigned items_accepted = 0;
	int unsigned chars_accepted = 0;
	int unsigned texts_done = 0;
	int unsigned tokens_checked = 0;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;

	// lexer state as the predictor sees it
	mode_t       lx_mode = MODE_IDLE;
	logic [15:0] lx_cursor = '0;
	logic [15:0] lx_start = '0;
	logic        lx_frac = 1'b0;

	function automatic logic is_digit(logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [15:0] gathered_len();
		return (lx_cursor >= lx_start) ? lx_cursor - lx_start : 16'd0;
	endfunction

	task automatic push_token(kind_t k, op_t o, logic [15:0] s, logic [15:0] l);
		token_t t;
		t.kind = k;
		t.op = o;
		t.start = s;
		t.length = l;
		t.last = 1'b0;
		expected_tokens.push_back(t);
	endtask

	task automatic start_token(logic [7:0] c);
		kind_t k;
		op_t   o;
		k = KIND_OPERATOR;
		o = OP_ASSIGN;
		if (is_blank(c))
			return;
		if (is_digit(c)) begin
			lx_mode = MODE_INT;
			lx_start = lx_cursor;
			return;
		end
		if (is_letter(c) || c == CH_UNDERSCORE) begin
			lx_mode = MODE_SYM;
			lx_start = lx_cursor;
			return;
		end
		case (c)
			CH_COMMA:     k = KIND_COMMA;
			CH_LPAREN:    k = KIND_LPAREN;
			CH_RPAREN:    k = KIND_RPAREN;
			CH_SEMICOLON: k = KIND_SEMICOLON;
			CH_EQUAL:     o = OP_ASSIGN;
			CH_PLUS:      o = OP_PLUS;
			CH_MINUS:     o = OP_MINUS;
			CH_STAR:      o = OP_MUL;
			CH_SLASH:     o = OP_DIV;
			CH_PERCENT:   o = OP_MOD;
			CH_CARET:     o = OP_POW;
			default:      k = KIND_ERROR;
		endcase
		push_token(k, o, lx_cursor, 16'd1);
		if (k == KIND_ERROR)
			lx_mode = MODE_ERR;
	endtask

	// a letter right after a number turns the number into an error token
	task automatic close_number(logic [7:0] c, kind_t k);
		if (is_letter(c)) begin
			push_token(KIND_ERROR, OP_ASSIGN, lx_start, gathered_len());
			lx_mode = MODE_ERR;
		end else begin
			push_token(k, OP_ASSIGN, lx_start, gathered_len());
			lx_mode = MODE_IDLE;
			start_token(c);
		end
	endtask

	task automatic lex_char(char_item_t it);
		int unsigned before_cnt;
		before_cnt = expected_tokens.size();
		if (it.cv) begin
			case (lx_mode)
				MODE_INT: begin
					if (!is_digit(it.code)) begin
						if (it.code == CH_DOT) begin
							lx_mode = MODE_DOT;
							lx_frac = 1'b0;
						end else begin
							close_number(it.code, KIND_INT);
						end
					end
				end
				MODE_DOT: begin
					if (is_digit(it.code))
						lx_frac = 1'b1;
					else
						close_number(it.code, lx_frac ? KIND_FLOAT : KIND_INT);
				end
				MODE_SYM: begin
					if (!(is_letter(it.code) || is_digit(it.code) ||
						it.code == CH_UNDERSCORE)) begin
						push_token(KIND_SYM, OP_ASSIGN, lx_start, gathered_len());
						lx_mode = MODE_IDLE;
						start_token(it.code);
					end
				end
				MODE_ERR: begin
				end
				default: begin
					lx_mode = MODE_IDLE;
					start_token(it.code);
				end
			endcase
			if (lx_cursor != CursorCap)
				lx_cursor = lx_cursor + 16'd1;
		end
		if (it.eot) begin
			if (lx_mode == MODE_INT)
				push_token(KIND_INT, OP_ASSIGN, lx_start, gathered_len());
			else if (lx_mode == MODE_DOT)
				push_token(lx_frac ? KIND_FLOAT : KIND_INT, OP_ASSIGN, lx_start, gathered_len());
			else if (lx_mode == MODE_SYM)
				push_token(KIND_SYM, OP_ASSIGN, lx_start, gathered_len());
			push_token(KIND_END, OP_ASSIGN, lx_cursor, 16'd0);
			lx_mode = MODE_IDLE;
			lx_cursor = '0;
			lx_start = '0;
			lx_frac = 1'b0;
			texts_done++;
		end
		if (expected_tokens.size() > before_cnt)
			expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endtask

	// stimulus helpers
	function automatic logic [7:0] random_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] random_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_letter();
		if ($urandom_range(0, 1) == 0)
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] random_word_char();
		int unsigned sel;
		sel = $urandom_range(0, 20);
		if (sel == 0)
			return CH_UNDERSCORE;
		if (sel <= 5)
			return random_digit();
		return random_letter();
	endfunction

	function automatic logic [7:0] random_punct();
		case ($urandom_range(0, 10))
			0:       return CH_COMMA;
			1:       return CH_LPAREN;
			2:       return CH_RPAREN;
			3:       return CH_SEMICOLON;
			4:       return CH_EQUAL;
			5:       return CH_PLUS;
			6:       return CH_MINUS;
			7:       return CH_STAR;
			8:       return CH_SLASH;
			9:       return CH_PERCENT;
			default: return CH_CARET;
		endcase
	endfunction

	function automatic logic [7:0] random_blank();
		if ($urandom_range(0, 5) == 0)
			return CH_SPACE;
		return 8'(CH_TAB + $urandom_range(0, 4));
	endfunction

	task automatic push_char(logic [7:0] code, logic cv, logic eot);
		char_item_t it;
		it.code = code;
		it.cv = cv;
		it.eot = eot;
		it.gap = src_calm ? 4'd0 : 4'($urandom_range(0, 9));
		char_queue.push_back(it);
		if (cv || eot)
			items_made++;
	endtask

	task automatic push_text(string s, logic end_last);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b1, end_last && (i == s.len() - 1));
	endtask

	task automatic push_digits(int unsigned lo, int unsigned hi);
		int unsigned n;
		n = $urandom_range(lo, hi);
		for (int unsigned i = 0; i < n; i++)
			push_char(random_digit(), 1'b1, 1'b0);
	endtask

	// mostly well-formed expressions with some noise mixed in
	task automatic add_random_text();
		int unsigned n_parts;
		int unsigned sel;
		int unsigned n;
		logic        prev_word;
		logic        is_word;
		n_parts = $urandom_range(1, 12);
		prev_word = 1'b0;
		src_calm = ($urandom_range(0, 4) == 0);
		for (int unsigned p = 0; p < n_parts; p++) begin
			sel = $urandom_range(0, 99);
			is_word = (sel < 56) || (sel >= 92 && sel < 95);
			if (is_word && prev_word && $urandom_range(0, 4) != 0)
				push_char(($urandom_range(0, 1) == 0) ? CH_SPACE : random_punct(), 1'b1, 1'b0);
			if (sel < 36) begin
				push_digits(1, 4);
				if (sel >= 22) begin
					push_char(CH_DOT, 1'b1, 1'b0);
					if (sel < 32)
						push_digits(1, 3);
				end
			end else if (sel < 56) begin
				push_char(($urandom_range(0, 5) == 0) ? CH_UNDERSCORE : random_letter(),
					1'b1, 1'b0);
				n = $urandom_range(0, 5);
				for (int unsigned i = 0; i < n; i++)
					push_char(random_word_char(), 1'b1, 1'b0);
			end else if (sel < 78) begin
				push_char(random_punct(), 1'b1, 1'b0);
			end else if (sel < 92) begin
				n = $urandom_range(1, 2);
				for (int unsigned i = 0; i < n; i++)
					push_char(random_blank(), 1'b1, 1'b0);
			end else if (sel < 95) begin
				push_digits(1, 3);
				push_char(random_letter(), 1'b1, 1'b0);
			end else if (sel < 98) begin
				push_char(random_byte(), 1'b1, 1'b0);
			end else begin
				push_char(random_byte(), 1'b0, 1'b0);
			end
			prev_word = is_word;
		end
		if ($urandom_range(0, 1) == 0)
			char_queue[char_queue.size() - 1].eot = 1'b1;
		else
			push_char(random_byte(), 1'b0, 1'b1);
	endtask

	// character driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_bus.valid <= 1'b0;
			char_bus.char_code <= '0;
			char_bus.char_valid <= 1'b0;
			char_bus.end_of_text <= 1'b0;
			staged = 1'b0;
			hold = 0;
		end else begin
			if (char_bus.valid && char_bus.ready) begin
				lex_char(on_bus);
				if (on_bus.cv)
					chars_accepted++;
				items_accepted++;
			end
			if (!char_bus.valid || char_bus.ready) begin
				if (!staged && char_queue.size() != 0) begin
					next_item = char_queue.pop_front();
					hold = 32'(next_item.gap);
					staged = 1'b1;
				end
				if (staged && hold == 0) begin
					on_bus = next_item;
					staged = 1'b0;
					char_bus.valid <= 1'b1;
					char_bus.char_code <= next_item.code;
					char_bus.char_valid <= next_item.cv;
					char_bus.end_of_text <= next_item.eot;
				end else begin
					char_bus.valid <= 1'b0;
					if (staged)
						hold--;
				end
			end
		end
	end

	// token monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_bus.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (token_bus.valid && token_bus.ready) begin
				if (expected_tokens.size() == 0) begin
					errors++;
					$display("%0t: unexpected token transaction: kind %0d op %0d start %0d len %0d",
						$time, token_bus.token_kind, token_bus.operator_code,
						token_bus.token_start, token_bus.token_length);
				end else begin
					want = expected_tokens.pop_front();
					tokens_checked++;
					if (token_bus.token_kind !== want.kind ||
						token_bus.operator_code !== want.op ||
						token_bus.token_start !== want.start ||
						token_bus.token_length !== want.length ||
						token_bus.last_of_run !== want.last) begin
						errors++;
						if (errors <= 30)
							$display({"%0t: token mismatch, expected kind %0d op %0d start %0d ",
								"len %0d last %0b, got kind %0d op %0d start %0d len %0d last %0b"},
								$time, want.kind, want.op, want.start, want.length, want.last,
								token_bus.token_kind, token_bus.operator_code,
								token_bus.token_start, token_bus.token_length,
								token_bus.last_of_run);
					end
				end
				if ($urandom_range(0, 31) == 0)
					sink_calm = !sink_calm;
				sink_wait = sink_calm ? 0 : $urandom_range(0, 9);
			end else if (sink_wait != 0) begin
				sink_wait--;
			end
			token_bus.ready <= (sink_wait == 0);
		end
	end

	// watchdog on stalled handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QuietLimit) begin
				$display("%0t: no transaction for %0d cycles, %0d tokens still expected",
					$time, QuietLimit, expected_tokens.size());
				$display("tb_expression_token_lexer failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned base;
		char_bus.valid = 1'b0;
		char_bus.char_code = '0;
		char_bus.char_valid = 1'b0;
		char_bus.end_of_text = 1'b0;
		token_bus.ready = 1'b0;

		// all kinds but the error kind, all operators, float, integer ending in a dot, end on a character
		push_text("_=1.5+2.*(a,b);%/^-", 1'b1);
		// number then underscore, symbol closed by an end-only item
		push_text("7_", 1'b0);
		push_char(8'h00, 1'b0, 1'b1);
		// empty item
		push_char(8'hFF, 1'b0, 1'b0);
		// number then letter, then ignored bytes until the end
		push_text("12x", 1'b0);
		push_char(8'hFF, 1'b1, 1'b0);
		push_char(8'h41, 1'b0, 1'b1);
		// unknown character and end in the same item
		push_char(8'h00, 1'b1, 1'b1);

		base = items_made;
		while (items_made - base < RandomItems)
			add_random_text();

		// longer symbol, then a number, punctuation and a high byte ending the text
		src_calm = 1'b1;
		push_char(CH_UNDERSCORE, 1'b1, 1'b0);
		for (int unsigned i = 0; i < LongSymbolChars; i++)
			push_char(random_word_char(), 1'b1, 1'b0);
		push_text(" 9+(", 1'b0);
		push_char(8'h80, 1'b1, 1'b1);
		src_calm = 1'b0;
		push_text("a+1", 1'b1);

		items_total = char_queue.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total)
			@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("checked %0d tokens from %0d characters in %0d texts", tokens_checked,
			chars_accepted, texts_done);
		$display("random stalls on both sides, error recovery and a %0d-character text",
			LongSymbolChars + 6);
		if (errors == 0) begin
			$display("tb_expression_token_lexer passed");
		end else begin
			$display("tb_expression_token_lexer failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
